// ===== hdl/zih_pkg.sv =====
// Package with the shared types and constants of the Zobrist incremental hash engine.
`timescale 1ns / 1ps
`default_nettype none

package zih_pkg;

    // Fixed field widths of the stream words, the configuration registers and the step counter.
    localparam int HASH_W     = 32;
    localparam int CMD_W      = 2;
    localparam int SLOT_W     = 6;
    localparam int KIDX_W     = 8;
    localparam int SLOTS_W    = 7;
    localparam int KBITS_W    = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;
    localparam int IN_DATA_W  = 144;
    localparam int IN_USER_W  = 3;
    localparam int OUT_DATA_W = 32;
    localparam int OUT_USER_W = 1;
    localparam int DIV_CNT_W  = 5;

    // Command codes carried in the low bits of the input tuser.
    localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_UPDATE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REHASH = 2'd2;

    // Kind codes of a result word.
    localparam logic KIND_UPDATE = 1'b0;
    localparam logic KIND_REHASH = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_SLOTS_IN_USE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_BITS     = 2'd1;

    // Reset values of the configuration registers.
    localparam logic [SLOTS_W-1:0] SLOTS_RESET = 7'd64;
    localparam logic [KBITS_W-1:0] KBITS_RESET = 4'd8;

    // Last step of the bit-serial remainder unit.
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = 5'd31;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_RD2  = 5'b00010,
        ST_FIN  = 5'b00100,
        ST_DIV  = 5'b01000,
        ST_RFIN = 5'b10000
    } t_state;

endpackage

`default_nettype wire

// ===== hdl/zobrist_incremental_hash_top.sv =====
// Top level of the Zobrist incremental hash engine: key table memory, hash register and sequencer.
// A load word is written at its accepting edge. An update word takes two key reads through the
// single key table port and, with tlast, then puts its hash in the result register; the next
// word can be taken in its finishing step unless a last element waits for the result register.
// A rehash word runs the bit-serial remainder unit (32 steps) and one key read. Reset is synchronous
// and active low; it clears the sequencer, the running hash and the result valid flag and restores
// the configuration registers. The key table is not cleared and holds nothing until loaded.
`timescale 1ns / 1ps
`default_nettype none

module zobrist_incremental_hash_top #(
    parameter int MAX_SLOTS    = 64,
    parameter int MAX_KEY_BITS = 8
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    // Configuration write port.
    input  wire                             i_cfg_we,
    input  wire [zih_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire [zih_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // Input stream.
    input  wire                             s_axis_tvalid,
    output logic                            s_axis_tready,
    // tdata from bit 0: slot[5:0], key_index[13:6], key_word[45:14], old_value[77:46],
    // new_value[109:78], base_hash[141:110], zero padding[143:142].
    input  wire [zih_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // tuser from bit 0: command[1:0], first[2].
    input  wire [zih_pkg::IN_USER_W-1:0]    s_axis_tuser,
    input  wire                             s_axis_tlast,
    // Result stream.
    output logic                            m_axis_tvalid,
    input  wire                             m_axis_tready,
    // tdata from bit 0: hash[31:0].
    output logic [zih_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    // tuser from bit 0: kind[0].
    output logic [zih_pkg::OUT_USER_W-1:0]  m_axis_tuser
);

    import zih_pkg::*;

    // The key table is addressed as {row, column}, one row of 2^MAX_KEY_BITS keys per slot.
    localparam int COLUMNS     = 1 << MAX_KEY_BITS;
    localparam int TABLE_DEPTH = MAX_SLOTS * COLUMNS;
    localparam int ROW_W       = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int ADDR_W      = ROW_W + MAX_KEY_BITS;

    localparam logic [10:0] SLOT_LIM = 11'(MAX_SLOTS);
    localparam logic [16:0] COL_LIM  = 17'(COLUMNS);
    localparam logic [4:0]  KB_LIM   = 5'(MAX_KEY_BITS);

    // Fields of the input word.
    logic [CMD_W-1:0]    w_cmd;
    logic [SLOT_W-1:0]   w_slot;
    logic [KIDX_W-1:0]   w_kidx;
    logic [HASH_W-1:0]   w_kword;
    logic [HASH_W-1:0]   w_old;
    logic [HASH_W-1:0]   w_new;
    logic [HASH_W-1:0]   w_base;
    logic                w_first;
    logic                w_last;

    assign w_slot  = s_axis_tdata[5:0];
    assign w_kidx  = s_axis_tdata[13:6];
    assign w_kword = s_axis_tdata[45:14];
    assign w_old   = s_axis_tdata[77:46];
    assign w_new   = s_axis_tdata[109:78];
    assign w_base  = s_axis_tdata[141:110];
    assign w_cmd   = s_axis_tuser[1:0];
    assign w_first = s_axis_tuser[2];
    assign w_last  = s_axis_tlast;

    // Registers.
    t_state                r_state, n_state;
    logic [SLOTS_W-1:0]    r_slots;
    logic [KBITS_W-1:0]    r_kbits;
    logic [HASH_W-1:0]     r_hash;
    logic [HASH_W-1:0]     r_base;
    logic                  r_first;
    logic                  r_last;
    logic                  r_apply;
    logic [ROW_W-1:0]      r_row;
    logic [MAX_KEY_BITS-1:0] r_col_new;
    logic [HASH_W-1:0]     r_key_old;
    logic [HASH_W-1:0]     r_key_rd;
    logic [HASH_W-1:0]     r_dsh;
    logic [SLOTS_W-1:0]    r_rem;
    logic [DIV_CNT_W-1:0]  r_cnt;
    logic                  r_out_valid;
    logic [HASH_W-1:0]     r_out_hash;
    logic                  r_out_kind;

    logic [HASH_W-1:0]     r_key_mem [TABLE_DEPTH];

    // Effective configuration, with out-of-range values clamped.
    logic [SLOTS_W-1:0]    eff_slots;
    logic [4:0]            eff_kb;
    logic [16:0]           mask_w;
    logic [MAX_KEY_BITS-1:0] vmask;

    always_comb begin
        if (r_slots == '0) begin
            eff_slots = SLOTS_W'(1);
        end else if ({4'b0, r_slots} > SLOT_LIM) begin
            eff_slots = SLOT_LIM[SLOTS_W-1:0];
        end else begin
            eff_slots = r_slots;
        end
        if (r_kbits == '0) begin
            eff_kb = 5'd1;
        end else if ({1'b0, r_kbits} > KB_LIM) begin
            eff_kb = KB_LIM;
        end else begin
            eff_kb = {1'b0, r_kbits};
        end
    end

    assign mask_w = (17'd1 << eff_kb) - 17'd1;
    assign vmask  = mask_w[MAX_KEY_BITS-1:0];

    // Address pieces taken from the input word.
    logic [ROW_W+SLOT_W-1:0]       slot_ext;
    logic [ROW_W-1:0]              in_row;
    logic [MAX_KEY_BITS+KIDX_W-1:0] kidx_ext;
    logic [MAX_KEY_BITS-1:0]       in_kcol;
    logic [MAX_KEY_BITS-1:0]       col_old;
    logic [MAX_KEY_BITS-1:0]       col_new;
    logic                          load_ok;
    logic                          apply;

    assign slot_ext = {{ROW_W{1'b0}}, w_slot};
    assign in_row   = slot_ext[ROW_W-1:0];
    assign kidx_ext = {{MAX_KEY_BITS{1'b0}}, w_kidx};
    assign in_kcol  = kidx_ext[MAX_KEY_BITS-1:0];
    assign col_old  = w_old[MAX_KEY_BITS-1:0] & vmask;
    assign col_new  = w_new[MAX_KEY_BITS-1:0] & vmask;
    assign load_ok  = ({5'b0, w_slot} < SLOT_LIM) && ({9'b0, w_kidx} < COL_LIM);
    // An element changes the hash only for a slot in use and a real change of value.
    assign apply    = ({1'b0, w_slot} < eff_slots) && (w_old != w_new);

    // Bit-serial remainder step: seed modulo the slot count, one dividend bit a cycle.
    logic [SLOTS_W:0]          div_t;
    logic [SLOTS_W:0]          div_d;
    logic [SLOTS_W-1:0]        rem_next;
    logic                      div_done;
    logic [ROW_W+SLOTS_W-1:0]  rem_ext;
    logic [ROW_W-1:0]          rh_row;
    logic [5:0]                rh_sh;
    logic [HASH_W-1:0]         rh_col_w;
    logic [MAX_KEY_BITS-1:0]   rh_col;

    assign div_t    = {r_rem, r_dsh[HASH_W-1]};
    assign div_d    = div_t - {1'b0, eff_slots};
    assign rem_next = (div_t >= {1'b0, eff_slots}) ? div_d[SLOTS_W-1:0] : div_t[SLOTS_W-1:0];
    assign div_done = (r_state == ST_DIV) && (r_cnt == DIV_LAST);
    assign rem_ext  = {{ROW_W{1'b0}}, rem_next};
    assign rh_row   = rem_ext[ROW_W-1:0];
    // The rehash column is the top key_bits bits of the seed.
    assign rh_sh    = 6'd32 - {1'b0, eff_kb};
    assign rh_col_w = r_base >> rh_sh;
    assign rh_col   = rh_col_w[MAX_KEY_BITS-1:0];

    // Handshake and sequencing.
    logic accept;
    logic out_free;
    logic fin_go;

    assign out_free      = !r_out_valid || m_axis_tready;
    // A finishing element that emits its hash needs the result register to be free.
    assign fin_go        = !r_last || out_free;
    // No word is taken while reset is held.
    assign s_axis_tready = i_rst_n &&
                           ((r_state == ST_IDLE) || ((r_state == ST_FIN) && fin_go));
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE, ST_FIN: begin
                if ((r_state == ST_FIN) && fin_go) begin
                    n_state = ST_IDLE;
                end
                if (accept) begin
                    case (w_cmd)
                        CMD_UPDATE: n_state = ST_RD2;
                        CMD_REHASH: n_state = ST_DIV;
                        default:    n_state = ST_IDLE;
                    endcase
                end
            end
            ST_RD2: begin
                n_state = ST_FIN;
            end
            ST_DIV: begin
                if (div_done) begin
                    n_state = ST_RFIN;
                end
            end
            ST_RFIN: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Key table port: one access a cycle, either a load write or one key read.
    logic              mem_we;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_addr;

    always_comb begin
        mem_we   = 1'b0;
        mem_re   = 1'b0;
        mem_addr = '0;
        if (accept && (w_cmd == CMD_LOAD)) begin
            mem_we   = load_ok;
            mem_addr = {in_row, in_kcol};
        end else if (accept && (w_cmd == CMD_UPDATE)) begin
            mem_re   = 1'b1;
            mem_addr = {in_row, col_old};
        end else if (r_state == ST_RD2) begin
            mem_re   = 1'b1;
            mem_addr = {r_row, r_col_new};
        end else if (div_done) begin
            mem_re   = 1'b1;
            mem_addr = {rh_row, rh_col};
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_key_mem[mem_addr] <= w_kword;
        end
        if (mem_re) begin
            r_key_rd <= r_key_mem[mem_addr];
        end
    end

    // The hash after a finishing element: first loads the base, then both keys fold in if it applies.
    logic [HASH_W-1:0] hash_start;
    logic [HASH_W-1:0] hash_next;

    assign hash_start = r_first ? r_base : r_hash;
    assign hash_next  = hash_start ^ (r_apply ? (r_key_old ^ r_key_rd) : '0);

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_slots     <= SLOTS_RESET;
            r_kbits     <= KBITS_RESET;
            r_hash      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_SLOTS_IN_USE: r_slots <= i_cfg_data;
                    CFG_KEY_BITS:     r_kbits <= i_cfg_data[KBITS_W-1:0];
                    default:          ;
                endcase
            end
            if ((r_state == ST_FIN) && fin_go) begin
                r_hash <= hash_next;
            end
            if (((r_state == ST_FIN) && r_last && out_free) ||
                ((r_state == ST_RFIN) && out_free)) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_base    <= w_base;
            r_first   <= w_first;
            r_last    <= w_last;
            r_apply   <= apply;
            r_row     <= in_row;
            r_col_new <= col_new;
            r_dsh     <= w_base;
            r_rem     <= '0;
            r_cnt     <= '0;
        end else if (r_state == ST_DIV) begin
            r_dsh <= {r_dsh[HASH_W-2:0], 1'b0};
            r_rem <= rem_next;
            r_cnt <= r_cnt + DIV_CNT_W'(1);
        end
        if (r_state == ST_RD2) begin
            r_key_old <= r_key_rd;
        end
        if ((r_state == ST_FIN) && r_last && out_free) begin
            r_out_hash <= hash_next;
            r_out_kind <= KIND_UPDATE;
        end else if ((r_state == ST_RFIN) && out_free) begin
            r_out_hash <= r_base ^ r_key_rd;
            r_out_kind <= KIND_REHASH;
        end
    end

    assign m_axis_tvalid   = r_out_valid;
    assign m_axis_tdata    = r_out_hash;
    assign m_axis_tuser[0] = r_out_kind;

    // Checks on the sequencer and the key table port.
    a_ready_states : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> (r_state == ST_IDLE) || (r_state == ST_FIN))
        else $error("input taken outside the idle or finishing state");

    a_rd2_to_fin : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RD2) |=> (r_state == ST_FIN))
        else $error("second key read not followed by the finishing step");

    a_rem_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_rem < eff_slots))
        else $error("remainder reached the slot count");

    a_write_on_load : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> accept && (w_cmd == CMD_LOAD) && !mem_re)
        else $error("key table written without a load word");

    a_rehash_waits : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RFIN) && r_out_valid && !m_axis_tready |=> (r_state == ST_RFIN))
        else $error("rehash result left while the result register was full");

endmodule

`default_nettype wire
